// File: rtl/core/steq_pkg.sv
// Package: shared types and codes for the sorted timer event queue.
`timescale 1ns / 1ps
`default_nettype none
package steq_pkg;
	localparam logic [1:0] OP_ADD_TICKS = 2'd0;
	localparam logic [1:0] OP_ADD_SECS  = 2'd1;
	localparam logic [1:0] OP_EXPIRE    = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOHDL  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] now;
		logic [63:0] delay;
		logic [15:0] handle;
	} steq_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        event_valid;
		logic [15:0] event_handle;
		logic [63:0] next_deadline;
		logic        program_timer;
		logic        last;
	} steq_out_t;
endpackage
`default_nettype wire

// File: rtl/core/steq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module steq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/core/steq_mul.sv
// Sequential 64x32 multiplier, modulo 2^64, one 16-bit slice of a per cycle.
`timescale 1ns / 1ps
`default_nettype none
module steq_mul (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] a,
	input  wire  [31:0] b,
	output logic        done,
	output logic [63:0] prod
);
	logic [63:0] a_q;
	logic [31:0] b_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic [47:0] part;

	// 16x32 slice product; a shifts down one slice per cycle
	assign part = a_q[15:0] * b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= busy_q && (cnt_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// slice k lands at bit 16*k; bits above 63 drop out
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			prod <= '0;
		end else if (busy_q) begin
			prod <= prod + ({16'd0, part} << {cnt_q, 4'd0});
			a_q  <= {16'd0, a_q[63:16]};
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/sorted_timer_event_queue_unit.sv
// Top level: sorted timer event queue with memory-backed table and sequencer.
//
// Channels: input beats (in_valid/in_stall, struct in_data) carry opcode, now,
// delay and handle; result beats (out_valid/out_stall, struct out_data) carry
// status, event flag, handle, next deadline, program flag and last. The
// config channel (cfg_valid/cfg_ready, cfg_data) writes timebase_hz; it is
// always ready. The user must write it only while the block is idle; no check.
// One item is worked at a time. An add reads the head, then scans from the
// tail, moving each later entry up one slot, and reads the head again for
// its result; a seconds add runs the multiply first. An expire compares
// entries from the head, one beat per due event, until one is not due;
// when anything expired it copies the remaining entries down, then it
// updates the count, reads the head and sends the closing beat. A dropped or
// ignored add and the unused opcode go straight to head read and result.
// Each result is registered in the output register; the next input beat is
// taken once the last beat has left. The one RAM read port sets the pace.
// Reset clears the entry count, the sequencer and the output register;
// table contents are left as they are. A stalled result holds in the output
// register and the sequencer waits on it; input stays stalled meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_event_queue_unit #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  steq_pkg::steq_in_t   in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output steq_pkg::steq_out_t  out_data,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [31:0]          cfg_data
);
	import steq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_HEAD  = 4'd2;
	localparam logic [3:0] S_HEADW = 4'd3;
	localparam logic [3:0] S_SRD   = 4'd4;
	localparam logic [3:0] S_SCMP  = 4'd5;
	localparam logic [3:0] S_ERD   = 4'd6;
	localparam logic [3:0] S_ECMP  = 4'd7;
	localparam logic [3:0] S_CRD   = 4'd8;
	localparam logic [3:0] S_CWR   = 4'd9;
	localparam logic [3:0] S_EMIT  = 4'd10;
	localparam logic [3:0] S_HRD   = 4'd11;
	localparam logic [3:0] S_HWT   = 4'd12;

	logic [3:0]    state_q;
	logic [31:0]   tb_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] due_q;
	logic [1:0]    op_q;
	logic [63:0]   now_q;
	logic [63:0]   exp_q;
	logic [15:0]   hdl_q;
	logic [1:0]    status_q;
	logic          newhead_q;

	// table memory
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wtime, rtime;
	logic [15:0]   whdl, rhdl;

	steq_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_time (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wtime), .raddr(raddr), .rdata(rtime));
	steq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_hdl (
		.clk(clk), .we(we), .waddr(waddr), .wdata(whdl), .raddr(raddr), .rdata(rhdl));

	logic        mul_start, mul_done;
	logic [63:0] mul_prod;
	steq_mul u_mul (.clk(clk), .arst_n(arst_n), .start(mul_start), .a(in_data.delay),
		.b(tb_q), .done(mul_done), .prod(mul_prod));

	logic        in_acc;
	logic        out_free;
	logic [15:0] hin;
	logic        due_hit;
	logic        emit;
	steq_out_t   emit_data;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE) || out_valid;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign hin       = {{(16 - HW){1'b0}}, in_data.handle[HW-1:0]};
	assign mul_start = in_acc && (in_data.opcode == OP_ADD_SECS) && (hin != '0)
		&& (count_q < CW'(DEPTH));
	// entry at the scan point is due; never true past the last entry
	assign due_hit   = (due_q < count_q) && (rtime <= now_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_q <= 32'hFFFF_FFFF;
		end else if (cfg_valid && cfg_ready) begin
			tb_q <= cfg_data;
		end
	end

	// combinational write/read control
	always_comb begin
		we    = 1'b0;
		waddr = AW'(idx_q);
		wtime = rtime;
		whdl  = rhdl;
		raddr = AW'(idx_q);
		unique case (state_q)
			S_HEAD: raddr = '0;
			S_HRD:  raddr = '0;
			S_HWT:  raddr = '0;
			S_SRD:  raddr = AW'(idx_q - CW'(1));
			S_SCMP: begin
				// rtime is entry idx-1: move it up, or drop the new one in here
				we = 1'b1;
				if (idx_q == '0 || rtime <= exp_q) begin
					wtime = exp_q;
					whdl  = hdl_q;
				end
			end
			S_CWR: begin
				we    = 1'b1;
				waddr = AW'(idx_q - due_q);
			end
			default: ;
		endcase
	end

	// result beat built from the current state
	always_comb begin
		emit      = 1'b0;
		emit_data = '0;
		if (state_q == S_ECMP && due_hit) begin
			emit                   = out_free;
			emit_data.status       = ST_OK;
			emit_data.event_valid  = 1'b1;
			emit_data.event_handle = rhdl;
		end else if (state_q == S_HWT) begin
			emit                    = out_free;
			emit_data.status        = status_q;
			emit_data.next_deadline = (count_q == '0) ? 64'd0 : rtime;
			emit_data.last          = 1'b1;
			if (op_q == OP_EXPIRE) begin
				emit_data.program_timer = (count_q != '0);
			end else if (status_q == ST_OK) begin
				emit_data.program_timer = newhead_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_data  <= '0;
		end else if (emit) begin
			out_valid <= 1'b1;
			out_data  <= emit_data;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			due_q     <= '0;
			exp_q     <= '0;
			status_q  <= ST_OK;
			newhead_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						idx_q     <= '0;
						due_q     <= '0;
						status_q  <= ST_OK;
						newhead_q <= 1'b0;
						if (in_data.opcode == OP_EXPIRE) begin
							state_q <= S_ERD;
						end else if (in_data.opcode == OP_ADD_TICKS
							|| in_data.opcode == OP_ADD_SECS) begin
							if (hin == '0) begin
								status_q <= ST_NOHDL;
								state_q  <= S_HRD;
							end else if (count_q >= CW'(DEPTH)) begin
								status_q <= ST_FULL;
								state_q  <= S_HRD;
							end else if (in_data.opcode == OP_ADD_SECS) begin
								state_q <= S_MUL;
							end else begin
								exp_q   <= in_data.now + in_data.delay;
								state_q <= S_HEAD;
							end
						end else begin
							state_q <= S_HRD;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						exp_q   <= now_q + mul_prod;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: state_q <= S_HEADW;
				S_HEADW: begin
					newhead_q <= (count_q == '0) || (exp_q < rtime);
					idx_q     <= count_q;
					state_q   <= (count_q == '0) ? S_SCMP : S_SRD;
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					// ties stay ahead of the new entry
					if (idx_q == '0 || rtime <= exp_q) begin
						count_q <= count_q + CW'(1);
						state_q <= S_HRD;
					end else begin
						idx_q   <= idx_q - CW'(1);
						state_q <= (idx_q == CW'(1)) ? S_SCMP : S_SRD;
					end
				end
				S_ERD: state_q <= S_ECMP;
				S_ECMP: begin
					if (due_hit) begin
						if (out_free) begin
							due_q   <= due_q + CW'(1);
							idx_q   <= idx_q + CW'(1);
							state_q <= S_ERD;
						end
					end else begin
						state_q <= (due_q != '0 && idx_q < count_q) ? S_CRD : S_EMIT;
					end
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= (idx_q + CW'(1) < count_q) ? S_CRD : S_EMIT;
				end
				S_EMIT: begin
					count_q <= count_q - due_q;
					state_q <= S_HRD;
				end
				S_HRD: state_q <= S_HWT;
				S_HWT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= in_data.opcode;
			now_q <= in_data.now;
			hdl_q <= hin;
		end
	end

	// the input side must be stalled whenever a result waits
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("input accepted while result pending");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("entry count above depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
endmodule
`default_nettype wire
